[src/pdl_pkg.sv]
`timescale 1ns / 1ps

package pdl_pkg;

  // Field widths of the channels and of the configuration port.
  localparam int DATA_W = 16;
  localparam int POS_W = 16;
  localparam int SCALE_W = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Arithmetic widths: differences, squares, their sum, the root and the delay.
  localparam int DIFF_W = POS_W + 1;
  localparam int SQ_W = 2 * DIFF_W;
  localparam int SUM_W = SQ_W + 1;
  localparam int ROOT_W = 17;
  localparam int WORK_W = SUM_W + 1;
  localparam int SQRT_STEPS = (SUM_W + 1) / 2;
  localparam int FRAC_W = 16;
  localparam int PROD_W = ROOT_W + SCALE_W;
  localparam int DELAY_W = PROD_W + 1 - FRAC_W;
  localparam int STEP_W = 5;

  localparam int RING_DEPTH_DEFAULT = 16384;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_X = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_Y = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_Z = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DELAY_SCALE = 3'd3;

  localparam logic [SCALE_W-1:0] DELAY_SCALE_RESET = 16'd8426;
  localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (FRAC_W - 1);

  // Axis select codes for the shared squaring multiplier.
  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;
  localparam logic [1:0] SEL_Z = 2'd2;

  // Step counts of the controller.
  localparam logic [STEP_W-1:0] SQUARE_LAST = 5'd3;
  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(SQRT_STEPS - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_LOAD,
    ST_ROOT,
    ST_SCALE,
    ST_ROUND,
    ST_LOOKUP,
    ST_READ,
    ST_FINISH
  } pdl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       square;
    logic [1:0] sel;
    logic       accum;
    logic       root_load;
    logic       root_step;
    logic       scale;
    logic       round;
    logic       lookup;
    logic       read;
    logic       load_out;
  } pdl_cmd_t;

endpackage

[src/pdl_in_if.sv]
`timescale 1ns / 1ps

interface pdl_in_if
  import pdl_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] source_sample;
  logic signed [POS_W-1:0]  mic_x;
  logic signed [POS_W-1:0]  mic_y;
  logic signed [POS_W-1:0]  mic_z;

  modport source(output valid, source_sample, mic_x, mic_y, mic_z, input ready);
  modport sink(input valid, source_sample, mic_x, mic_y, mic_z, output ready);
endinterface

[src/pdl_out_if.sv]
`timescale 1ns / 1ps

interface pdl_out_if
  import pdl_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] heard_sample;
  logic                     sample_valid;

  modport source(output valid, heard_sample, sample_valid, input ready);
  modport sink(input valid, heard_sample, sample_valid, output ready);
endinterface

[src/pdl_ctrl.sv]
`timescale 1ns / 1ps

module pdl_ctrl
  import pdl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output pdl_cmd_t cmd
);

  pdl_state_t        state;
  pdl_state_t        state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              out_valid_next;

  // State, step counter and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    step_next = step;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        // No request is taken while reset is held.
        in_ready = !rst;
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          step_next = '0;
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        // One square per cycle; the sum takes each square in the cycle after the multiplier forms it.
        cmd.square = (step != SQUARE_LAST);
        cmd.sel = step[1:0];
        cmd.accum = (step != '0);
        if (step == SQUARE_LAST) begin
          state_next = ST_LOAD;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_LOAD: begin
        cmd.root_load = 1'b1;
        step_next = '0;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (step == ROOT_LAST) begin
          state_next = ST_SCALE;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        cmd.read = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // Wait here while the previous result is still held.
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // The output request stays until the receiver takes it.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

[src/pdl_datapath.sv]
`timescale 1ns / 1ps

module pdl_datapath
  import pdl_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  pdl_cmd_t                 cmd,
  input  logic                     cfg_write,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic signed [DATA_W-1:0] source_sample,
  input  logic signed [POS_W-1:0]  mic_x,
  input  logic signed [POS_W-1:0]  mic_y,
  input  logic signed [POS_W-1:0]  mic_z,
  output logic signed [DATA_W-1:0] heard_sample,
  output logic                     sample_valid
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int EXT_W = DELAY_W + 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);
  localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(RING_DEPTH);

  logic signed [POS_W-1:0]  source_x;
  logic signed [POS_W-1:0]  source_y;
  logic signed [POS_W-1:0]  source_z;
  logic [SCALE_W-1:0]       delay_scale;

  logic [PTR_W-1:0]         write_pointer;
  logic [CNT_W-1:0]         samples_written;
  logic [PTR_W-1:0]         item_pointer;

  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] dz;
  logic signed [DIFF_W-1:0] diff_sel;
  logic signed [SQ_W-1:0]   sq_full;
  logic [SQ_W-1:0]          sq;
  logic [SUM_W-1:0]         sum;

  logic [SUM_W-1:0]         rem;
  logic [WORK_W-1:0]        root;
  logic [SUM_W-1:0]         root_bit;
  logic [WORK_W-1:0]        trial;

  logic [PROD_W-1:0]        prod;
  logic [PROD_W:0]          rounded;
  logic [DELAY_W-1:0]       delay;

  logic [EXT_W-1:0]         delay_ext;
  logic [EXT_W-1:0]         ptr_ext;
  logic [EXT_W-1:0]         addr_calc;
  logic                     hit;
  logic [PTR_W-1:0]         rd_addr;
  logic signed [DATA_W-1:0] rd_data;

  logic signed [DATA_W-1:0] sample_ring [RING_DEPTH];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_x <= '0;
      source_y <= '0;
      source_z <= '0;
      delay_scale <= DELAY_SCALE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SOURCE_X: source_x <= cfg_data;
        REG_SOURCE_Y: source_y <= cfg_data;
        REG_SOURCE_Z: source_z <= cfg_data;
        REG_DELAY_SCALE: delay_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // Write pointer wraps at the ring depth; the fill count saturates there.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      samples_written <= '0;
    end else if (cmd.accept) begin
      write_pointer <= (write_pointer == PTR_LAST) ? '0 : write_pointer + 1'b1;
      if (samples_written != CNT_FULL) begin
        samples_written <= samples_written + 1'b1;
      end
    end
  end

  // Capture the item: its ring slot and the offsets to the source.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_pointer <= write_pointer;
      dx <= DIFF_W'(mic_x) - DIFF_W'(source_x);
      dy <= DIFF_W'(mic_y) - DIFF_W'(source_y);
      dz <= DIFF_W'(mic_z) - DIFF_W'(source_z);
    end
  end

  // Shared squaring multiplier, one axis per cycle.
  always_comb begin
    case (cmd.sel)
      SEL_X: diff_sel = dx;
      SEL_Y: diff_sel = dy;
      default: diff_sel = dz;
    endcase
  end

  assign sq_full = diff_sel * diff_sel;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sum <= '0;
    end else if (cmd.accum) begin
      sum <= sum + SUM_W'(sq);
    end
    if (cmd.square) begin
      sq <= sq_full;
    end
  end

  // Integer square root, one result bit per cycle.
  assign trial = root + WORK_W'(root_bit);

  always_ff @(posedge clk) begin
    if (cmd.root_load) begin
      rem <= sum;
      root <= '0;
      root_bit <= SUM_W'(1) << (2 * (SQRT_STEPS - 1));
    end else if (cmd.root_step) begin
      if (WORK_W'(rem) >= trial) begin
        rem <= rem - trial[SUM_W-1:0];
        root <= (root >> 1) + WORK_W'(root_bit);
      end else begin
        root <= root >> 1;
      end
      root_bit <= root_bit >> 2;
    end
  end

  // Scale the distance to samples and round half up.
  assign rounded = {1'b0, prod} + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      prod <= PROD_W'(root[ROOT_W-1:0]) * PROD_W'(delay_scale);
    end
    if (cmd.round) begin
      delay <= rounded[PROD_W:FRAC_W];
    end
  end

  // Check the delay against the fill count and form the read address.
  assign delay_ext = EXT_W'(delay);
  assign ptr_ext = EXT_W'(item_pointer);

  always_comb begin
    if (delay_ext <= ptr_ext) begin
      addr_calc = ptr_ext - delay_ext;
    end else begin
      addr_calc = ptr_ext + DEPTH_EXT - delay_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit <= (delay_ext < EXT_W'(samples_written));
      rd_addr <= addr_calc[PTR_W-1:0];
    end
  end

  // Sample ring: written on acceptance, read once per item.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_ring[write_pointer] <= source_sample;
    end
    if (cmd.read) begin
      rd_data <= sample_ring[rd_addr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      heard_sample <= hit ? rd_data : '0;
      sample_valid <= hit;
    end
  end

endmodule

[src/propagation_delay_line_unit.sv]
`timescale 1ns / 1ps

// Propagation delay line for one microphone hearing one point source.
// Requests arrive on ingress: a source sample and the microphone position in
// millimetres. Each request writes the sample into the ring and yields one
// request on egress: the sample heard through the distance-dependent delay,
// and a flag that is low (with a zero sample) when that sample is not stored.
// Source position and delay scale are set through the write port (cfg_write,
// cfg_index, cfg_data); other indexes are ignored. The user is to write them
// only while the unit is idle; the unit itself does not enforce this. It
// holds one item at a time and takes no new input until the last result is
// loaded for egress. Each item makes three passes through the shared squaring
// multiplier, then the bit-serial square root yields one root bit per cycle.
// When egress stalls, the held result stays on the port; the unit still
// accepts the next input and finishes it, then waits until the held result
// is taken. Reset empties the ring (fill count and write pointer to zero),
// clears the source position and loads the default delay scale.
module propagation_delay_line_unit
  import pdl_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  pdl_in_if.sink                 ingress,
  pdl_out_if.source              egress,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  pdl_cmd_t cmd;

  pdl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ingress.valid),
    .in_ready  (ingress.ready),
    .out_valid (egress.valid),
    .out_ready (egress.ready),
    .cmd       (cmd)
  );

  pdl_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .source_sample (ingress.source_sample),
    .mic_x         (ingress.mic_x),
    .mic_y         (ingress.mic_y),
    .mic_z         (ingress.mic_z),
    .heard_sample  (egress.heard_sample),
    .sample_valid  (egress.sample_valid)
  );

  // Only one item is in flight: acceptance closes the input side.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    ingress.valid && ingress.ready |=> !ingress.ready)
    else $error("input accepted while an item is in flight");

  // A missing sample is reported as zero.
  a_invalid_is_zero: assert property (@(posedge clk) disable iff (rst)
    egress.valid && !egress.sample_valid |-> egress.heard_sample == '0)
    else $error("invalid result carries a nonzero sample");

  // A new result appears only when an item has just finished.
  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(egress.valid) |-> $past(!ingress.ready))
    else $error("result offered without a finished item");

endmodule

[bench/propagation_delay_line_unit_test.sv]
`timescale 1ns / 1ps

module propagation_delay_line_unit_test;
  import pdl_pkg::*;

  localparam int RING_SIZE = RING_DEPTH_DEFAULT;
  // Slowest correct run: every request waits out the longest gaps on both sides.
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD = 400;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_REQUESTS = 210;
  localparam int EDGE_REQUESTS = 80;
  localparam int DIR_ROWS = 23;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd6;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic signed [POS_W-1:0]  mic_x;
    logic signed [POS_W-1:0]  mic_y;
    logic signed [POS_W-1:0]  mic_z;
  } listen_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] heard_sample;
    logic                     sample_valid;
  } heard_t;

  typedef enum logic {ROW_REQUEST, ROW_REGISTER} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  reg_data;
    listen_req_t            req;
    logic                   known;
    heard_t                 typed;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pdl_in_if ingress_ch();
  pdl_out_if egress_ch();

  propagation_delay_line_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .ingress   (ingress_ch),
    .egress    (egress_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Model state: ring of written samples, fill level and source setup.
  logic [DATA_W-1:0] echo_ring [RING_SIZE];
  int ring_fill = 0;
  int ring_head = 0;
  logic signed [POS_W-1:0] src_x = '0;
  logic signed [POS_W-1:0] src_y = '0;
  logic signed [POS_W-1:0] src_z = '0;
  logic [SCALE_W-1:0] delay_scale = DELAY_SCALE_RESET;

  heard_t pending_heard [$];
  int mismatch_count = 0;
  int cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Floor of the square root, one result bit at a time from the top.
  function automatic longint root_floor(input longint n);
    longint root;
    longint trial;
    root = 0;
    for (int b = 17; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Store the sample, measure the distance and look up what the mic hears now.
  task automatic predict_heard(input listen_req_t r, output heard_t h);
    longint dx, dy, dz, path_len, lag;
    int slot;
    echo_ring[ring_head] = r.sample;
    if (ring_fill < RING_SIZE) ring_fill++;
    dx = longint'(r.mic_x) - longint'(src_x);
    dy = longint'(r.mic_y) - longint'(src_y);
    dz = longint'(r.mic_z) - longint'(src_z);
    path_len = root_floor(dx * dx + dy * dy + dz * dz);
    // Scaled distance rounded to the nearest sample, halves going up.
    lag = (path_len * longint'(delay_scale) + (longint'(1) << (FRAC_W - 1))) >> FRAC_W;
    if (lag < ring_fill) begin
      slot = (ring_head + RING_SIZE - int'(lag)) % RING_SIZE;
      h.heard_sample = echo_ring[slot];
      h.sample_valid = 1'b1;
    end else begin
      h = '0;
    end
    ring_head = (ring_head + 1) % RING_SIZE;
  endtask

  function automatic dir_row_t request_row(input logic [15:0] s, input logic [15:0] x,
                                           input logic [15:0] y, input logic [15:0] z,
                                           input logic known, input logic [15:0] heard,
                                           input logic ok);
    dir_row_t row;
    row = '0;
    row.kind = ROW_REQUEST;
    row.req = '{s, x, y, z};
    row.known = known;
    row.typed = '{heard, ok};
    return row;
  endfunction

  function automatic dir_row_t register_row(input logic [CFG_INDEX_W-1:0] index,
                                            input logic [CFG_DATA_W-1:0] data);
    dir_row_t row;
    row = '0;
    row.kind = ROW_REGISTER;
    row.reg_index = index;
    row.reg_data = data;
    return row;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    else if (roll < 85) return $urandom_range(1, 3);
    else if (roll < 97) return $urandom_range(4, 30);
    else return $urandom_range(60, 150);
  endfunction

  // Mic placed near the source most of the time so that delays stay in the ring.
  function automatic listen_req_t random_request();
    listen_req_t r;
    int mode;
    int span;
    r.sample = DATA_W'($urandom);
    if ($urandom_range(0, 15) == 0) r.sample = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    mode = $urandom_range(0, 99);
    span = 1 << $urandom_range(0, 14);
    r.mic_x = src_x + POS_W'($urandom_range(0, 2 * span)) - POS_W'(span);
    r.mic_y = src_y;
    r.mic_z = src_z;
    if (mode < 60) begin
      r.mic_y = src_y + POS_W'($urandom_range(0, 2 * span)) - POS_W'(span);
      r.mic_z = src_z + POS_W'($urandom_range(0, 2 * span)) - POS_W'(span);
    end else if (mode >= 80) begin
      r.mic_x = POS_W'($urandom);
      r.mic_y = POS_W'($urandom);
      r.mic_z = POS_W'($urandom);
    end
    return r;
  endfunction

  // With the source at the origin and full scale, the delay equals the distance;
  // aim at the edge of what the ring holds.
  function automatic listen_req_t wrap_request();
    listen_req_t r;
    int reach;
    int d;
    reach = (ring_fill < RING_SIZE) ? ring_fill + 1 : RING_SIZE;
    case ($urandom_range(0, 9))
      0: d = reach - 1;
      1: d = reach;
      default: d = $urandom_range(0, reach + 100);
    endcase
    if ($urandom_range(0, 1)) d = -d;
    r = '0;
    r.sample = DATA_W'($urandom);
    case ($urandom_range(0, 2))
      0: r.mic_x = POS_W'(d);
      1: r.mic_y = POS_W'(d);
      default: r.mic_z = POS_W'(d);
    endcase
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    case (index)
      REG_SOURCE_X: src_x = data;
      REG_SOURCE_Y: src_y = data;
      REG_SOURCE_Z: src_z = data;
      REG_DELAY_SCALE: delay_scale = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure_source(input logic [15:0] sx, input logic [15:0] sy,
                                  input logic [15:0] sz, input logic [15:0] scale);
    write_reg(REG_SOURCE_X, sx);
    write_reg(REG_SOURCE_Y, sy);
    write_reg(REG_SOURCE_Z, sz);
    write_reg(REG_DELAY_SCALE, scale);
  endtask

  // Stop offering and wait until every outstanding result has been taken.
  task automatic pause_for_results();
    ingress_ch.valid <= 1'b0;
    while (pending_heard.size() != 0) @(posedge clk);
  endtask

  // Offer one request after an optional gap; predict once it is accepted.
  task automatic send_request(input listen_req_t r, input int gap, input logic known,
                              input heard_t typed);
    heard_t h;
    if (gap > 0) begin
      ingress_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ingress_ch.valid <= 1'b1;
    ingress_ch.source_sample <= r.sample;
    ingress_ch.mic_x <= r.mic_x;
    ingress_ch.mic_y <= r.mic_y;
    ingress_ch.mic_z <= r.mic_z;
    do @(posedge clk); while (!ingress_ch.ready);
    predict_heard(r, h);
    if (known) h = typed;
    pending_heard = {pending_heard, h};
  endtask

  task automatic check_heard(input logic signed [DATA_W-1:0] heard, input logic ok);
    heard_t want;
    if (pending_heard.size() == 0) begin
      mismatch_count++;
      $display("%0t: result with none pending, heard_sample %h sample_valid %b",
               $time, heard, ok);
    end else begin
      want = pending_heard.pop_front();
      if (heard !== want.heard_sample) begin
        mismatch_count++;
        $display("%0t: heard_sample expected %h actual %h", $time, want.heard_sample, heard);
      end
      if (ok !== want.sample_valid) begin
        mismatch_count++;
        $display("%0t: sample_valid expected %b actual %b", $time, want.sample_valid, ok);
      end
    end
  endtask

  // Result side: check each request taken, then decide on ready for the next cycle.
  initial begin
    int gap_left;
    int hold_left;
    int taken;
    gap_left = 0;
    hold_left = 0;
    taken = 0;
    egress_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && egress_ch.valid && egress_ch.ready) begin
        check_heard(egress_ch.heard_sample, egress_ch.sample_valid);
        taken++;
        // Two long holds let the unit fill up and stall its input.
        if (taken == 80 || taken == 1000) hold_left = LONG_HOLD;
        else gap_left = (taken % 256 < 48) ? 0 : pick_gap();
      end
      if (rst) begin
        egress_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        egress_ch.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        egress_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 19) == 0) begin
        gap_left = $urandom_range(0, 2);
        egress_ch.ready <= 1'b0;
      end else begin
        egress_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("propagation_delay_line_unit test failed");
    $finish;
  end

  // Stimulus: directed table, random phases, then a run aimed at the edge of the ring.
  initial begin
    dir_row_t dir_rows [DIR_ROWS];
    ingress_ch.valid = 1'b0;
    ingress_ch.source_sample = '0;
    ingress_ch.mic_x = '0;
    ingress_ch.mic_y = '0;
    ingress_ch.mic_z = '0;

    dir_rows = '{
      // Fresh after reset, mic on the source: the sample comes straight back.
      request_row(16'h1234, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h1234, 1'b1),
      request_row(16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h8000, 1'b1),
      // Far corners: the delay is longer than anything stored.
      request_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 16'h0000, 1'b0),
      request_row(16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 1'b1, 16'h0000, 1'b0),
      request_row(16'h0005, 16'h0001, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0),
      request_row(16'h00A5, 16'h0008, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0),
      request_row(16'h5A5A, 16'h0000, 16'h0000, 16'hFF38, 1'b0, 16'h0000, 1'b0),
      // Zero scale always returns the current sample.
      register_row(REG_DELAY_SCALE, 16'h0000),
      request_row(16'h0ABC, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b1, 16'h0ABC, 1'b1),
      // Source in an extreme corner, full scale.
      register_row(REG_SOURCE_X, 16'h8000),
      register_row(REG_SOURCE_Y, 16'h7FFF),
      register_row(REG_SOURCE_Z, 16'h8000),
      register_row(REG_DELAY_SCALE, 16'hFFFF),
      request_row(16'h3C3C, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b1, 16'h0000, 1'b0),
      request_row(16'hC3C3, 16'h8000, 16'h7FFF, 16'h8000, 1'b1, 16'hC3C3, 1'b1),
      request_row(16'h1111, 16'h8003, 16'h7FFF, 16'h8004, 1'b0, 16'h0000, 1'b0),
      // A write to an unknown index must leave the source alone.
      register_row(REG_UNMAPPED, 16'h1234),
      request_row(16'h2222, 16'h8000, 16'h7FFF, 16'h8000, 1'b1, 16'h2222, 1'b1),
      // Half scale exercises rounding of halves.
      register_row(REG_DELAY_SCALE, 16'h8000),
      request_row(16'h3333, 16'h8001, 16'h7FFF, 16'h8000, 1'b0, 16'h0000, 1'b0),
      request_row(16'h4444, 16'h8003, 16'h7FFF, 16'h8000, 1'b0, 16'h0000, 1'b0),
      register_row(REG_DELAY_SCALE, 16'h0001),
      request_row(16'h5555, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0, 16'h0000, 1'b0)
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REGISTER) begin
        pause_for_results();
        write_reg(dir_rows[i].reg_index, dir_rows[i].reg_data);
      end else begin
        send_request(dir_rows[i].req, pick_gap(), dir_rows[i].known, dir_rows[i].typed);
      end
    end

    // Random phases, each with its own source placement and scale.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      pause_for_results();
      case (p)
        0: configure_source(16'($urandom), 16'($urandom), 16'($urandom), DELAY_SCALE_RESET);
        1: configure_source(16'($urandom), 16'($urandom), 16'($urandom), 16'h0000);
        2: configure_source(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF);
        3: begin
          configure_source(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
          write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
        end
        4: configure_source(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001);
        default: configure_source(16'h0000, 16'h0000, 16'h0000, DELAY_SCALE_RESET);
      endcase
      for (int k = 0; k < PHASE_REQUESTS; k++) begin
        send_request(random_request(), (k % 200 < 40) ? 0 : pick_gap(), 1'b0, '0);
      end
    end

    // Requests aimed at the edge of what the ring holds so far.
    pause_for_results();
    configure_source(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    for (int k = 0; k < EDGE_REQUESTS; k++) begin
      send_request(wrap_request(), ($urandom_range(0, 49) == 0) ? pick_gap() : 0, 1'b0, '0);
    end

    pause_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("propagation_delay_line_unit test passed");
    end else begin
      $display("propagation_delay_line_unit test failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/pdl_pkg.sv
src/pdl_in_if.sv
src/pdl_out_if.sv
src/pdl_ctrl.sv
src/pdl_datapath.sv
src/propagation_delay_line_unit.sv
bench/propagation_delay_line_unit_test.sv
